// ===== design/hcbd_pkg.sv =====
// hcbd_pkg: shared types, widths and character codes for the chunked body decoder
// no dependencies; every other design file refers to it by scoped names
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int STAT_W  = 2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_BUSY  = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ERROR = 2'd2;

    // characters that delimit the size line
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

    // largest size that may still take one more hex digit
    localparam logic [COUNT_W-1:0] SIZE_LIMIT = 32'h0FFF_FFFF;

    // capacity register value after reset
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 32'hFFFF_FFFF;

    // one decoded result
    typedef struct packed {
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic [STAT_W-1:0]   status;
        logic [COUNT_W-1:0]  total_len;
    } result_t;

    // hex digit decode: is_hex flag in bit 4, value in bits 3:0
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== design/hcbd_ifs.sv =====
// hcbd_ifs: valid/ready channel interfaces for body bytes, results and configuration
// depends on hcbd_pkg for field widths
`timescale 1ns / 1ps

interface hcbd_body_if;
    logic                        valid;
    logic                        ready;
    logic                        start_req;
    logic [hcbd_pkg::BYTE_W-1:0] in_byte;
    logic                        in_last;

    modport source (output valid, start_req, in_byte, in_last, input ready);
    modport sink   (input valid, start_req, in_byte, in_last, output ready);
endinterface

interface hcbd_result_if;
    logic                         valid;
    logic                         ready;
    logic                         out_valid;
    logic [hcbd_pkg::BYTE_W-1:0]  out_byte;
    logic [hcbd_pkg::STAT_W-1:0]  status;
    logic [hcbd_pkg::COUNT_W-1:0] total_len;

    modport source (output valid, out_valid, out_byte, status, total_len, input ready);
    modport sink   (input valid, out_valid, out_byte, status, total_len, output ready);
endinterface

interface hcbd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [hcbd_pkg::COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/hcbd_core.sv =====
// hcbd_core: decoder state registers and the per-byte next-state and result logic
// depends on hcbd_pkg
`timescale 1ns / 1ps

module hcbd_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         start_req,
    input  logic [hcbd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                         in_last,
    input  logic [hcbd_pkg::COUNT_W-1:0] out_capacity,
    output hcbd_pkg::result_t            res
);

    localparam logic [2:0] PH_SIZE     = 3'd0;
    localparam logic [2:0] PH_SKIP     = 3'd1;
    localparam logic [2:0] PH_DATA     = 3'd2;
    localparam logic [2:0] PH_TRAIL    = 3'd3;
    localparam logic [2:0] PH_TRAIL_LF = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;
    localparam logic [2:0] PH_ERR      = 3'd6;

    logic [2:0]                   phase_reg,  phase_next;
    logic [hcbd_pkg::COUNT_W-1:0] chunk_reg,  chunk_next;
    logic                         digit_reg,  digit_next;
    logic [hcbd_pkg::COUNT_W-1:0] left_reg,   left_next;
    logic [hcbd_pkg::COUNT_W-1:0] count_reg,  count_next;

    logic [2:0]                   cur_phase;
    logic [hcbd_pkg::COUNT_W-1:0] cur_chunk;
    logic                         cur_digit;
    logic [hcbd_pkg::COUNT_W-1:0] cur_left;
    logic [hcbd_pkg::COUNT_W-1:0] cur_count;

    logic [hcbd_pkg::COUNT_W-1:0] base_chunk;
    logic                         base_digit;
    logic [4:0]                   hex;
    logic                         over_cap;
    logic [2:0]                   end_phase;
    logic [2:0]                   sz_phase;
    logic [hcbd_pkg::COUNT_W-1:0] sz_chunk;
    logic                         sz_digit;
    logic [hcbd_pkg::COUNT_W-1:0] left_dec;
    logic [2:0]                   step_phase;
    logic                         emit;

    // start of a new body clears the state seen by this byte
    always_comb
    begin
        cur_phase = start_req ? PH_SIZE : phase_reg;
        cur_chunk = start_req ? '0 : chunk_reg;
        cur_digit = start_req ? 1'b0 : digit_reg;
        cur_left  = start_req ? '0 : left_reg;
        cur_count = start_req ? '0 : count_reg;
    end

    // a byte in place of the payload trailer opens a fresh size line
    assign base_chunk = (cur_phase == PH_TRAIL) ? '0 : cur_chunk;
    assign base_digit = (cur_phase == PH_TRAIL) ? 1'b0 : cur_digit;
    assign hex        = hcbd_pkg::hex_decode(in_byte);
    assign left_dec   = cur_left - 32'd1;

    // capacity check at the end of a size line
    assign over_cap = ({1'b0, cur_count} + {1'b0, cur_chunk}) > {1'b0, out_capacity};

    always_comb
    begin
        if (cur_chunk == '0)
        begin
            end_phase = PH_DONE;
        end
        else if (over_cap)
        begin
            end_phase = PH_ERR;
        end
        else
        begin
            end_phase = PH_DATA;
        end
    end

    // one character of the size line
    always_comb
    begin
        sz_phase = PH_SIZE;
        sz_chunk = base_chunk;
        sz_digit = base_digit;
        priority if (in_byte == hcbd_pkg::CH_LF)
        begin
            sz_phase = base_digit ? end_phase : PH_ERR;
        end
        else if (in_byte == hcbd_pkg::CH_CR || in_byte == hcbd_pkg::CH_SEMI)
        begin
            sz_phase = base_digit ? PH_SKIP : PH_ERR;
        end
        else if (!hex[4] || base_chunk > hcbd_pkg::SIZE_LIMIT)
        begin
            sz_phase = PH_ERR;
        end
        else
        begin
            sz_chunk = {base_chunk[hcbd_pkg::COUNT_W-5:0], hex[3:0]};
            sz_digit = 1'b1;
        end
    end

    // per-phase next state
    always_comb
    begin
        step_phase = cur_phase;
        chunk_next = cur_chunk;
        digit_next = cur_digit;
        left_next  = cur_left;
        count_next = cur_count;
        emit       = 1'b0;
        unique case (cur_phase)
            PH_SIZE:
            begin
                step_phase = sz_phase;
                chunk_next = sz_chunk;
                digit_next = sz_digit;
                if (sz_phase == PH_DATA)
                begin
                    left_next = cur_chunk;
                end
            end
            PH_SKIP:
            begin
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    step_phase = end_phase;
                    if (end_phase == PH_DATA)
                    begin
                        left_next = cur_chunk;
                    end
                end
            end
            PH_DATA:
            begin
                emit       = 1'b1;
                count_next = cur_count + 32'd1;
                left_next  = left_dec;
                if (left_dec == '0)
                begin
                    step_phase = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                if (in_byte == hcbd_pkg::CH_CR)
                begin
                    step_phase = PH_TRAIL_LF;
                end
                else if (in_byte == hcbd_pkg::CH_LF)
                begin
                    step_phase = PH_SIZE;
                    chunk_next = '0;
                    digit_next = 1'b0;
                end
                else
                begin
                    step_phase = sz_phase;
                    chunk_next = sz_chunk;
                    digit_next = sz_digit;
                end
            end
            PH_TRAIL_LF:
            begin
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    step_phase = PH_SIZE;
                    chunk_next = '0;
                    digit_next = 1'b0;
                end
                else
                begin
                    step_phase = PH_ERR;
                end
            end
            PH_DONE:
            begin
                step_phase = PH_DONE;
            end
            default:
            begin
                step_phase = PH_ERR;
            end
        endcase
    end

    // running out of input before the terminating chunk is an error
    assign phase_next = (in_last && step_phase != PH_DONE) ? PH_ERR : step_phase;

    // result for this byte
    always_comb
    begin
        res.out_valid = emit;
        res.out_byte  = emit ? in_byte : '0;
        res.total_len = count_next;
        if (phase_next == PH_DONE)
        begin
            res.status = hcbd_pkg::STATUS_DONE;
        end
        else if (phase_next == PH_ERR)
        begin
            res.status = hcbd_pkg::STATUS_ERROR;
        end
        else
        begin
            res.status = hcbd_pkg::STATUS_BUSY;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            chunk_reg <= '0;
            digit_reg <= 1'b0;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            digit_reg <= digit_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    // completion is sticky until a new body starts
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !start_req && phase_reg == PH_DONE) |=> (phase_reg == PH_DONE))
        else $error("completed body left the done phase");

    // errors are sticky until a new body starts
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !start_req && phase_reg == PH_ERR) |=> (phase_reg == PH_ERR))
        else $error("error phase left without a restart");

    // payload count moves only on payload bytes
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !start_req && phase_reg != PH_DATA) |=> (count_reg == $past(count_reg)))
        else $error("payload count changed outside the payload phase");

endmodule

// ===== design/hcbd_out_reg.sv =====
// hcbd_out_reg: result register that holds one decoded result until the sink takes it
// depends on hcbd_pkg and hcbd_ifs
`timescale 1ns / 1ps

module hcbd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hcbd_pkg::result_t res,
    output logic              can_load,
    hcbd_result_if.source     result
);

    logic              valid_reg, valid_next;
    hcbd_pkg::result_t data_reg;

    // free when empty or drained this cycle
    assign can_load   = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid     = valid_reg;
    assign result.out_valid = data_reg.out_valid;
    assign result.out_byte  = data_reg.out_byte;
    assign result.status    = data_reg.status;
    assign result.total_len = data_reg.total_len;

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// http_chunked_body_decoder: top level, input register, capacity register, core and result register
// depends on hcbd_pkg, hcbd_ifs, hcbd_core and hcbd_out_reg
`timescale 1ns / 1ps
//
//  channel  dir  handshake        contents
//  body     in   valid / ready    start_req, in_byte, in_last
//  result   out  valid / ready    out_valid, out_byte, status, total_len
//  cfg      in   valid / ready    data -> out_capacity
//
//  one body byte per cycle sustained while the result sink keeps up; each byte gives one result
//  per-byte work is one pass from the input register through the decode logic to the result register
//  reset: capacity is all ones, decoder waits for a size line, no result held
//  a stalled result holds the input register; body ready drops only while both are full
//  cfg is always ready; the user writes it only while the decoder is idle, not enforced by the block

module http_chunked_body_decoder (
    input  logic          clk,
    input  logic          rst_n,
    hcbd_body_if.sink     body,
    hcbd_result_if.source result,
    hcbd_cfg_if.sink      cfg
);

    logic                         in_valid_reg, in_valid_next;
    logic                         start_reg;
    logic [hcbd_pkg::BYTE_W-1:0]  byte_reg;
    logic                         last_reg;
    logic [hcbd_pkg::COUNT_W-1:0] capacity_reg;
    logic                         can_load;
    logic                         step;
    logic                         take;
    hcbd_pkg::result_t            res;

    // capacity register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= hcbd_pkg::CAPACITY_RESET;
        end
        else if (cfg.valid)
        begin
            capacity_reg <= cfg.data;
        end
    end

    // input register
    assign step          = in_valid_reg && can_load;
    assign body.ready    = !in_valid_reg || can_load;
    assign take          = body.valid && body.ready;
    assign in_valid_next = take || (in_valid_reg && !can_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            start_reg <= body.start_req;
            byte_reg  <= body.in_byte;
            last_reg  <= body.in_last;
        end
    end

    hcbd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .start_req    (start_reg),
        .in_byte      (byte_reg),
        .in_last      (last_reg),
        .out_capacity (capacity_reg),
        .res          (res)
    );

    hcbd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (res),
        .can_load (can_load),
        .result   (result)
    );

endmodule

// ===== sim/tb_http_chunked_body_decoder.sv =====
// tb_http_chunked_body_decoder: self-checking bench for the chunked body decoder, with a
// cycle-free predictor, bursty body driver, stalling result sink and capacity register phases
// depends on hcbd_pkg, hcbd_ifs and http_chunked_body_decoder
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

    // decoder phases tracked by the predictor
    typedef enum logic [2:0] {
        DEC_SIZE     = 3'd0,
        DEC_SKIP     = 3'd1,
        DEC_DATA     = 3'd2,
        DEC_TRAIL    = 3'd3,
        DEC_TRAIL_LF = 3'd4,
        DEC_DONE     = 3'd5,
        DEC_ERR      = 3'd6
    } dec_phase_e;

    // result sink stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_STALL  = 3;

    typedef struct {
        logic                        start_req;
        logic [hcbd_pkg::BYTE_W-1:0] in_byte;
        logic                        in_last;
    } body_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hcbd_body_if   body ();
    hcbd_result_if result ();
    hcbd_cfg_if    cfg ();

    http_chunked_body_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body),
        .result (result),
        .cfg    (cfg)
    );

    always #2 clk = ~clk;

    body_req_t                   body_queue[$];
    hcbd_pkg::result_t           decoded_queue[$];
    logic [hcbd_pkg::BYTE_W-1:0] frame[$];
    int unsigned                 mismatch_count = 0;

    // predictor state
    logic [hcbd_pkg::COUNT_W-1:0] capacity_reg;
    dec_phase_e                   dec_phase;
    logic [hcbd_pkg::COUNT_W-1:0] size_acc;
    logic                         have_digit;
    logic [hcbd_pkg::COUNT_W-1:0] bytes_remaining;
    logic [hcbd_pkg::COUNT_W-1:0] emitted_count;

    // driver and sink state
    bit                body_taken = 1'b0;
    int unsigned       burst_left = 1;
    int unsigned       gap_left = 0;
    int                rx_mode = RX_FREE;
    int unsigned       rx_mode_left = 0;
    int unsigned       rx_tick = 0;
    hcbd_pkg::result_t oldest;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_decoder();
        dec_phase       = DEC_SIZE;
        size_acc        = '0;
        have_digit      = 1'b0;
        bytes_remaining = '0;
        emitted_count   = '0;
    endfunction

    // size line finished at its LF
    function automatic void close_size_line();
        if (size_acc == '0)
        begin
            dec_phase = DEC_DONE;
        end
        else if ({1'b0, emitted_count} + {1'b0, size_acc} > {1'b0, capacity_reg})
        begin
            dec_phase = DEC_ERR;
        end
        else
        begin
            bytes_remaining = size_acc;
            dec_phase       = DEC_DATA;
        end
    endfunction

    function automatic void take_size_char(input logic [hcbd_pkg::BYTE_W-1:0] c);
        logic       is_hex;
        logic [3:0] nib;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (c == hcbd_pkg::CH_LF)
        begin
            if (!have_digit)
                dec_phase = DEC_ERR;
            else
                close_size_line();
        end
        else if (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_SEMI)
        begin
            dec_phase = have_digit ? DEC_SKIP : DEC_ERR;
        end
        else
        begin
            if (c >= "0" && c <= "9")
                nib = 4'(c - 8'h30);
            else if (c >= "a" && c <= "f")
                nib = 4'(c - 8'h61 + 8'd10);
            else if (c >= "A" && c <= "F")
                nib = 4'(c - 8'h41 + 8'd10);
            else
                is_hex = 1'b0;
            if (!is_hex)
                dec_phase = DEC_ERR;
            else if (size_acc > hcbd_pkg::SIZE_LIMIT)
                dec_phase = DEC_ERR;
            else
            begin
                size_acc   = {size_acc[hcbd_pkg::COUNT_W-5:0], 4'h0}
                             + (hcbd_pkg::COUNT_W)'(nib);
                have_digit = 1'b1;
            end
        end
    endfunction

    function automatic hcbd_pkg::result_t decode_byte(input body_req_t req);
        hcbd_pkg::result_t r;
        r = '0;
        if (req.start_req)
            clear_decoder();
        case (dec_phase)
            DEC_SIZE: take_size_char(req.in_byte);
            DEC_SKIP:
            begin
                if (req.in_byte == hcbd_pkg::CH_LF)
                    close_size_line();
            end
            DEC_DATA:
            begin
                r.out_valid = 1'b1;
                r.out_byte  = req.in_byte;
                emitted_count++;
                bytes_remaining--;
                if (bytes_remaining == '0)
                    dec_phase = DEC_TRAIL;
            end
            DEC_TRAIL:
            begin
                if (req.in_byte == hcbd_pkg::CH_CR)
                    dec_phase = DEC_TRAIL_LF;
                else
                begin
                    // missing terminator: the byte opens the next size line
                    size_acc   = '0;
                    have_digit = 1'b0;
                    dec_phase  = DEC_SIZE;
                    if (req.in_byte != hcbd_pkg::CH_LF)
                        take_size_char(req.in_byte);
                end
            end
            DEC_TRAIL_LF:
            begin
                if (req.in_byte == hcbd_pkg::CH_LF)
                begin
                    size_acc   = '0;
                    have_digit = 1'b0;
                    dec_phase  = DEC_SIZE;
                end
                else
                    dec_phase = DEC_ERR;
            end
            DEC_DONE: ;
            default: dec_phase = DEC_ERR;
        endcase
        // early end of input
        if (req.in_last && dec_phase != DEC_DONE)
            dec_phase = DEC_ERR;
        if (dec_phase == DEC_DONE)
            r.status = hcbd_pkg::STATUS_DONE;
        else if (dec_phase == DEC_ERR)
            r.status = hcbd_pkg::STATUS_ERROR;
        else
            r.status = hcbd_pkg::STATUS_BUSY;
        r.total_len = emitted_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // body driver: bursts with random gaps, changes on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (body.valid && !body_taken)
            begin
                // request still waiting for ready
            end
            else if (gap_left > 0)
            begin
                body.valid <= 1'b0;
                gap_left--;
            end
            else if (body_queue.size() > 0)
            begin
                body.valid     <= 1'b1;
                body.start_req <= body_queue[0].start_req;
                body.in_byte   <= body_queue[0].in_byte;
                body.in_last   <= body_queue[0].in_last;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                body.valid <= 1'b0;
            end
            body_taken = 1'b0;
        end
    end

    // result sink stall pattern, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(RX_FREE, RX_STALL);
                rx_mode_left = $urandom_range(16, 160);
            end
            else
                rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_FREE:   result.ready <= 1'b1;
                RX_RANDOM: result.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: result.ready <= (rx_tick % 4) == 0;
                default:   result.ready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request acceptance and result check on the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (body.valid && body.ready)
            begin
                decoded_queue.push_back(decode_byte(body_queue.pop_front()));
                body_taken = 1'b1;
            end
            if (result.valid && result.ready)
            begin
                if (decoded_queue.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    oldest = decoded_queue.pop_front();
                    if (result.out_valid !== oldest.out_valid)
                        report_mismatch($sformatf("out_valid %b, want %b",
                                                  result.out_valid, oldest.out_valid));
                    if (result.out_byte !== oldest.out_byte)
                        report_mismatch($sformatf("out_byte %h, want %h",
                                                  result.out_byte, oldest.out_byte));
                    if (result.status !== oldest.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  result.status, oldest.status));
                    if (result.total_len !== oldest.total_len)
                        report_mismatch($sformatf("total_len %0d, want %0d",
                                                  result.total_len, oldest.total_len));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i]);
    endtask

    // queue the framed body, start on its first byte
    task automatic emit_frame(input bit mark_last);
        body_req_t req;
        for (int i = 0; i < frame.size(); i++)
        begin
            req.start_req = (i == 0);
            req.in_byte   = frame[i];
            req.in_last   = mark_last && (i == frame.size() - 1);
            body_queue.push_back(req);
        end
        frame.delete();
    endtask

    // hex size in mixed case, optional leading zeros and extension, CRLF or bare LF
    task automatic add_size_line(input int unsigned size);
        string                       hex;
        logic [hcbd_pkg::BYTE_W-1:0] ch;
        hex = $sformatf("%0h", size);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) frame.push_back("0");
        for (int i = 0; i < hex.len(); i++)
        begin
            ch = hex[i];
            if (ch >= "a" && $urandom_range(0, 1) == 1)
                ch = ch - 8'h20;
            frame.push_back(ch);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            frame.push_back(hcbd_pkg::CH_SEMI);
            repeat ($urandom_range(0, 3))
            begin
                ch = 8'($urandom);
                frame.push_back(ch == hcbd_pkg::CH_LF ? "x" : ch);
            end
        end
        if ($urandom_range(0, 3) != 0)
            frame.push_back(hcbd_pkg::CH_CR);
        frame.push_back(hcbd_pkg::CH_LF);
    endtask

    // one random body: mostly well formed, some corrupted, truncated or plain noise
    task automatic build_body();
        int unsigned n_chunks;
        int unsigned size;
        int unsigned keep;
        int unsigned pick;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        end
        else
        begin
            n_chunks = $urandom_range(0, 3);
            repeat (n_chunks)
            begin
                size = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 5);
                add_size_line(size);
                repeat (size) frame.push_back(8'($urandom));
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    frame.push_back(hcbd_pkg::CH_CR);
                    frame.push_back(hcbd_pkg::CH_LF);
                end
                else if (pick < 9)
                    frame.push_back(hcbd_pkg::CH_LF);
            end
            add_size_line(0);
            // bytes after the last chunk are ignored
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) frame.push_back(8'($urandom));
            if ($urandom_range(0, 5) == 0)
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
            begin
                keep = $urandom_range(1, frame.size());
                while (frame.size() > keep)
                    void'(frame.pop_back());
            end
        end
        emit_frame($urandom_range(0, 3) != 0);
    endtask

    task automatic run_random_phase(input int unsigned target);
        int unsigned queued;
        int unsigned before_size;
        queued = 0;
        while (queued < target)
        begin
            before_size = body_queue.size();
            build_body();
            queued += body_queue.size() - before_size;
        end
    endtask

    task automatic wait_idle();
        while (body_queue.size() != 0 || decoded_queue.size() != 0 || body.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [hcbd_pkg::COUNT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        capacity_reg = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        body.valid     = 1'b0;
        body.start_req = 1'b0;
        body.in_byte   = '0;
        body.in_last   = 1'b0;
        result.ready   = 1'b0;
        cfg.valid      = 1'b0;
        cfg.data       = '0;
        capacity_reg   = hcbd_pkg::CAPACITY_RESET;
        clear_decoder();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bare LF line ends, top byte value, completion then an ignored byte
        put_text("1\n");
        frame.push_back(8'hFF);
        put_text("\n0\nq");
        emit_frame(1'b1);
        // extension with CR, zero byte, missing payload terminator
        put_text("2;\015\n");
        frame.push_back(8'h00);
        put_text("a0\n");
        emit_frame(1'b1);
        // bad size character, then a byte ignored after the error
        put_text("G1");
        emit_frame(1'b1);
        // empty size line
        put_text("\015");
        emit_frame(1'b0);
        // lone CR after payload
        put_text("1\nx\015y");
        emit_frame(1'b0);
        // size overflow on the ninth digit
        put_text("100000000");
        emit_frame(1'b0);
        // input ends in the middle of a size line
        put_text("3");
        emit_frame(1'b1);

        run_random_phase(80);
        write_capacity('0);
        run_random_phase(80);
        write_capacity((hcbd_pkg::COUNT_W)'($urandom_range(4, 24)));
        run_random_phase(80);
        write_capacity(hcbd_pkg::CAPACITY_RESET);
        run_random_phase(80);
        write_capacity((hcbd_pkg::COUNT_W)'($urandom));
        run_random_phase(80);

        wait_idle();
        if (mismatch_count == 0)
            $display("tb_http_chunked_body_decoder passed");
        else
            $display("tb_http_chunked_body_decoder failed");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb_http_chunked_body_decoder failed");
        $finish;
    end

endmodule

// ===== http_chunked_body_decoder.f =====
design/hcbd_pkg.sv
design/hcbd_ifs.sv
design/hcbd_core.sv
design/hcbd_out_reg.sv
design/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
